### rtl/act_pkg.sv
// Shared types, codes and seven-segment tables for the answer countdown timer.
// Used by answer_countdown_timer; no dependencies.
`timescale 1ns / 1ps

package act_pkg;

    typedef enum logic [1:0] {
        KIND_START  = 2'd0,
        KIND_ANSWER = 2'd1,
        KIND_DEBNC  = 2'd2,
        KIND_COUNT  = 2'd3
    } kind_t;

    typedef enum logic [0:0] {
        CFG_START_SECONDS   = 1'b0,
        CFG_ALTERNATE_TICKS = 1'b1
    } cfg_index_t;

    localparam logic [3:0] DASH_CODE     = 4'd10;
    localparam logic [3:0] MAX_SECONDS   = 4'd9;
    localparam logic [3:0] MAX_TENTHS    = 4'd9;
    localparam logic [3:0] RESET_SECONDS = 4'd5;
    localparam logic [3:0] RESET_ALT     = 4'd14;

    localparam logic [2:0] ANS_NONE = 3'd0;
    localparam logic [2:0] ANS_A    = 3'd1;
    localparam logic [2:0] ANS_B    = 3'd2;
    localparam logic [2:0] ANS_C    = 3'd3;
    localparam logic [2:0] ANS_D    = 3'd4;

    typedef struct packed {
        logic [2:0] answer_out;
        logic       is_counting;
        logic [3:0] right_code;
        logic [3:0] left_code;
        logic [7:0] right_segments;
        logic [7:0] left_segments;
    } result_t;

    // Left digit: decimal point lit (bit 7 low).
    function automatic logic [7:0] left_seg(input logic [3:0] code);
        logic [7:0] seg;
        unique case (code)
            4'd0:    seg = 8'h40;
            4'd1:    seg = 8'h79;
            4'd2:    seg = 8'h24;
            4'd3:    seg = 8'h30;
            4'd4:    seg = 8'h19;
            4'd5:    seg = 8'h12;
            4'd6:    seg = 8'h02;
            4'd7:    seg = 8'h78;
            4'd8:    seg = 8'h00;
            4'd9:    seg = 8'h10;
            default: seg = 8'h3F;
        endcase
        return seg;
    endfunction

    // Right digit: decimal point dark; letters A..D follow the dash.
    function automatic logic [7:0] right_seg(input logic [3:0] code);
        logic [7:0] seg;
        unique case (code)
            4'd0:    seg = 8'hC0;
            4'd1:    seg = 8'hF9;
            4'd2:    seg = 8'hA4;
            4'd3:    seg = 8'hB0;
            4'd4:    seg = 8'h99;
            4'd5:    seg = 8'h92;
            4'd6:    seg = 8'h82;
            4'd7:    seg = 8'hF8;
            4'd8:    seg = 8'h80;
            4'd9:    seg = 8'h90;
            4'd11:   seg = 8'h88;
            4'd12:   seg = 8'h83;
            4'd13:   seg = 8'hC6;
            4'd14:   seg = 8'hA1;
            default: seg = 8'hBF;
        endcase
        return seg;
    endfunction

endpackage

### rtl/answer_countdown_timer.sv
// Top level of the answer countdown timer: event decode, countdown state,
// display alternation and a two-deep output stage. Depends on act_pkg.
`timescale 1ns / 1ps

// Usage:
//   s_* channel: one event per beat. s_tuser[1:0] is the kind (start press,
//   answer press, debounce tick, count tick); s_tdata[3:0] carries the four
//   active-low answer lines (A in bit 0 .. D in bit 3).
//   m_* channel: exactly one result beat per event, holding both segment
//   patterns, both digit codes, the counting flag and the answer code.
//   cfg_* channel: register writes (0 start seconds, 1 alternate ticks),
//   always ready; write only while the block is idle.
// Output: each result is registered, in the output or the skid register.
// Throughput: one event per cycle while s_tready is high; the state update
//   is a single pass of small compares and decrements between the state
//   registers and the output register.
// Stall: an output register plus a skid register sit between the sides, so
//   one more event is taken while a result waits; s_tready drops only when
//   both hold results.
// Reset: rst_n clears all state to its power-up values (time 5.0, counting,
//   start enabled) and empties the output stage.
module answer_countdown_timer (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [7:0]             s_tdata,   // [3:0] answer_lines, [7:4] zero
    input  logic [1:0]             s_tuser,   // [1:0] kind
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // [7:0] left_segments, [15:8] right_segments, [19:16] left_code,
    // [23:20] right_code, [24] is_counting, [27:25] answer_out, [31:28] zero
    output logic [31:0]            m_tdata,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  act_pkg::cfg_index_t    cfg_index,
    input  logic [3:0]             cfg_data
);
    import act_pkg::*;

    logic [3:0] start_seconds_reg;
    logic [3:0] alternate_ticks_reg;

    logic       count_running_reg,    count_running_next;
    logic       debounce_running_reg, debounce_running_next;
    logic       start_enable_reg,     start_enable_next;
    logic       answer_enable_reg,    answer_enable_next;
    logic       counting_flag_reg,    counting_flag_next;
    logic       half_tenth_reg,       half_tenth_next;
    logic [3:0] seconds_digit_reg,    seconds_digit_next;
    logic [3:0] tenths_digit_reg,     tenths_digit_next;
    logic [2:0] answer_code_reg,      answer_code_next;
    logic [3:0] saved_seconds_reg,    saved_seconds_next;
    logic [3:0] saved_tenths_reg,     saved_tenths_next;
    logic [3:0] alternate_count_reg,  alternate_count_next;

    logic       out_valid_reg;
    result_t    out_data_reg;
    logic       skid_valid_reg;
    result_t    skid_data_reg;
    result_t    result_next;

    kind_t      kind;
    logic [3:0] lines;
    logic       in_fire;
    logic       out_fire;

    assign kind      = kind_t'(s_tuser);
    assign lines     = s_tdata[3:0];
    assign s_tready  = !skid_valid_reg;
    assign in_fire   = s_tvalid && s_tready;
    assign out_fire  = out_valid_reg && m_tready;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {4'd0, out_data_reg};
    assign cfg_ready = 1'b1;

    always_comb
    begin
        count_running_next    = count_running_reg;
        debounce_running_next = debounce_running_reg;
        start_enable_next     = start_enable_reg;
        answer_enable_next    = answer_enable_reg;
        counting_flag_next    = counting_flag_reg;
        half_tenth_next       = half_tenth_reg;
        seconds_digit_next    = seconds_digit_reg;
        tenths_digit_next     = tenths_digit_reg;
        answer_code_next      = answer_code_reg;
        saved_seconds_next    = saved_seconds_reg;
        saved_tenths_next     = saved_tenths_reg;
        alternate_count_next  = alternate_count_reg;

        unique case (kind)
            KIND_START:
            begin
                if (start_enable_reg)
                begin
                    if (counting_flag_reg)
                    begin
                        count_running_next    = 1'b1;
                        debounce_running_next = 1'b1;
                        start_enable_next     = 1'b0;
                    end
                    else
                    begin
                        // re-arm: reload time, timers stay stopped
                        counting_flag_next    = 1'b1;
                        answer_code_next      = ANS_NONE;
                        seconds_digit_next    = (start_seconds_reg > MAX_SECONDS) ?
                                                MAX_SECONDS : start_seconds_reg;
                        tenths_digit_next     = 4'd0;
                        count_running_next    = 1'b0;
                        debounce_running_next = 1'b0;
                        start_enable_next     = 1'b1;
                        answer_enable_next    = 1'b0;
                    end
                end
            end
            KIND_ANSWER:
            begin
                if (answer_enable_reg && counting_flag_reg)
                begin
                    count_running_next    = 1'b1;
                    debounce_running_next = 1'b1;
                    answer_enable_next    = 1'b0;
                    // later lines win; no line low keeps the old code
                    if (!lines[3])
                        answer_code_next = ANS_D;
                    else if (!lines[2])
                        answer_code_next = ANS_C;
                    else if (!lines[1])
                        answer_code_next = ANS_B;
                    else if (!lines[0])
                        answer_code_next = ANS_A;
                    counting_flag_next = 1'b0;
                    saved_seconds_next = seconds_digit_reg;
                    saved_tenths_next  = tenths_digit_reg;
                end
            end
            KIND_DEBNC:
            begin
                if (debounce_running_reg)
                begin
                    debounce_running_next = 1'b0;
                    start_enable_next     = 1'b1;
                end
            end
            KIND_COUNT:
            begin
                if (count_running_reg)
                begin
                    answer_enable_next = 1'b1;
                    if (counting_flag_reg)
                    begin
                        half_tenth_next = !half_tenth_reg;
                        if (half_tenth_reg)
                        begin
                            if (tenths_digit_reg == 4'd0)
                            begin
                                if (seconds_digit_reg != 4'd0)
                                begin
                                    seconds_digit_next = seconds_digit_reg - 4'd1;
                                    tenths_digit_next  = MAX_TENTHS;
                                end
                            end
                            else
                            begin
                                tenths_digit_next = tenths_digit_reg - 4'd1;
                            end
                        end
                        // freeze on reaching 0.0
                        if (seconds_digit_next == 4'd0 && tenths_digit_next == 4'd0)
                        begin
                            saved_seconds_next = 4'd0;
                            saved_tenths_next  = 4'd0;
                            counting_flag_next = 1'b0;
                        end
                    end
                    else if (alternate_count_reg >= alternate_ticks_reg)
                    begin
                        if (seconds_digit_reg == DASH_CODE)
                        begin
                            seconds_digit_next = saved_seconds_reg;
                            tenths_digit_next  = saved_tenths_reg;
                        end
                        else
                        begin
                            seconds_digit_next = DASH_CODE;
                            tenths_digit_next  =
                                (answer_code_reg >= ANS_A && answer_code_reg <= ANS_D) ?
                                DASH_CODE + {1'b0, answer_code_reg} : DASH_CODE;
                        end
                        alternate_count_next = 4'd0;
                    end
                    else
                    begin
                        alternate_count_next = alternate_count_reg + 4'd1;
                    end
                end
            end
            default:
            begin
            end
        endcase

        result_next.left_segments  = left_seg(seconds_digit_next);
        result_next.right_segments = right_seg(tenths_digit_next);
        result_next.left_code      = seconds_digit_next;
        result_next.right_code     = tenths_digit_next;
        result_next.is_counting    = counting_flag_next;
        result_next.answer_out     = answer_code_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_seconds_reg   <= RESET_SECONDS;
            alternate_ticks_reg <= RESET_ALT;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_START_SECONDS:   start_seconds_reg   <= cfg_data;
                CFG_ALTERNATE_TICKS: alternate_ticks_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_running_reg    <= 1'b0;
            debounce_running_reg <= 1'b0;
            start_enable_reg     <= 1'b1;
            answer_enable_reg    <= 1'b0;
            counting_flag_reg    <= 1'b1;
            half_tenth_reg       <= 1'b0;
            seconds_digit_reg    <= RESET_SECONDS;
            tenths_digit_reg     <= 4'd0;
            answer_code_reg      <= ANS_NONE;
            saved_seconds_reg    <= 4'd0;
            saved_tenths_reg     <= 4'd0;
            alternate_count_reg  <= 4'd0;
        end
        else if (in_fire)
        begin
            count_running_reg    <= count_running_next;
            debounce_running_reg <= debounce_running_next;
            start_enable_reg     <= start_enable_next;
            answer_enable_reg    <= answer_enable_next;
            counting_flag_reg    <= counting_flag_next;
            half_tenth_reg       <= half_tenth_next;
            seconds_digit_reg    <= seconds_digit_next;
            tenths_digit_reg     <= tenths_digit_next;
            answer_code_reg      <= answer_code_next;
            saved_seconds_reg    <= saved_seconds_next;
            saved_tenths_reg     <= saved_tenths_next;
            alternate_count_reg  <= alternate_count_next;
        end
    end

    // Output register with a skid entry behind it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || out_fire)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= in_fire;
            end
        end
        else if (in_fire)
        begin
            // output held: park this beat in the skid entry
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || out_fire)
        begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : result_next;
        end
        else if (in_fire)
        begin
            skid_data_reg <= result_next;
        end
    end

endmodule

### tb/answer_countdown_timer_test.sv
// Self-checking bench for answer_countdown_timer: quiz rounds and noise driven as events,
// each result beat compared with a local model of the countdown and display.
// Depends on act_pkg and the answer_countdown_timer RTL.
`timescale 1ns / 1ps

module answer_countdown_timer_test;

    import act_pkg::*;

    typedef struct {
        kind_t      kind;
        logic [3:0] lines;
    } buzz_t;

    // Segment patterns, entry 0 in the lowest byte.
    localparam logic [11*8-1:0] LEFT_SEGS = {
        8'h3F, 8'h10, 8'h00, 8'h78, 8'h02, 8'h12, 8'h19, 8'h30, 8'h24, 8'h79, 8'h40
    };
    localparam logic [15*8-1:0] RIGHT_SEGS = {
        8'hA1, 8'hC6, 8'h83, 8'h88, 8'hBF, 8'h90, 8'h80, 8'hF8, 8'h82, 8'h92,
        8'h99, 8'hB0, 8'hA4, 8'hF9, 8'hC0
    };

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;   // [3:0] answer_lines, [7:4] zero
    logic [1:0]  s_tuser = 2'b00;   // [1:0] kind
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;           // segments, codes, is_counting, answer_out
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    cfg_index_t  cfg_index = CFG_START_SECONDS;
    logic [3:0]  cfg_data = 4'd0;

    buzz_t   buzz_q[$];
    result_t display_q[$];
    int      idle_pct = 0;
    int      stall_pct = 0;
    bit      hold_sender = 1'b0;
    int      error_count = 0;

    // Local copy of the timer state, at its reset values.
    logic [3:0] q_cfg_start = RESET_SECONDS;
    logic [3:0] q_cfg_alt   = RESET_ALT;
    bit         q_cnt_run   = 1'b0;
    bit         q_deb_run   = 1'b0;
    bit         q_start_en  = 1'b1;
    bit         q_ans_en    = 1'b0;
    bit         q_counting  = 1'b1;
    bit         q_half      = 1'b0;
    logic [3:0] q_sec       = RESET_SECONDS;
    logic [3:0] q_ten       = 4'd0;
    logic [2:0] q_answer    = ANS_NONE;
    logic [3:0] q_sav_sec   = 4'd0;
    logic [3:0] q_sav_ten   = 4'd0;
    logic [3:0] q_alt_cnt   = 4'd0;

    answer_countdown_timer u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    task automatic flag_mismatch(input string what, input int got, input int want);
        error_count++;
        $display("%0t mismatch %s: got %0d want %0d", $realtime, what, got, want);
    endtask

    task automatic step_quiz_timer(input kind_t k, input logic [3:0] lines,
                                   output result_t r);
        case (k)
            KIND_START:
            begin
                if (q_start_en)
                begin
                    q_cnt_run  = 1'b1;
                    q_deb_run  = 1'b1;
                    q_start_en = 1'b0;
                    // Frozen: re-arm and stop, a further press starts
                    if (!q_counting)
                    begin
                        q_counting = 1'b1;
                        q_answer   = ANS_NONE;
                        q_sec      = (q_cfg_start > MAX_SECONDS) ? MAX_SECONDS : q_cfg_start;
                        q_ten      = 4'd0;
                        q_deb_run  = 1'b0;
                        q_cnt_run  = 1'b0;
                        q_start_en = 1'b1;
                        q_ans_en   = 1'b0;
                    end
                end
            end
            KIND_ANSWER:
            begin
                if (q_ans_en && q_counting)
                begin
                    q_cnt_run = 1'b1;
                    q_deb_run = 1'b1;
                    q_ans_en  = 1'b0;
                    // Later lines override, so D wins
                    if (!lines[0]) q_answer = ANS_A;
                    if (!lines[1]) q_answer = ANS_B;
                    if (!lines[2]) q_answer = ANS_C;
                    if (!lines[3]) q_answer = ANS_D;
                    q_counting = 1'b0;
                    q_sav_sec  = q_sec;
                    q_sav_ten  = q_ten;
                end
            end
            KIND_DEBNC:
            begin
                if (q_deb_run)
                begin
                    q_deb_run  = 1'b0;
                    q_start_en = 1'b1;
                end
            end
            default:
            begin
                if (q_cnt_run)
                begin
                    q_ans_en = 1'b1;
                    if (q_counting)
                    begin
                        if (q_half)
                        begin
                            if (q_ten == 4'd0)
                            begin
                                if (q_sec != 4'd0)
                                begin
                                    q_sec = q_sec - 4'd1;
                                    q_ten = MAX_TENTHS;
                                end
                            end
                            else
                            begin
                                q_ten = q_ten - 4'd1;
                            end
                            q_half = 1'b0;
                        end
                        else
                        begin
                            q_half = 1'b1;
                        end
                        if (q_sec == 4'd0 && q_ten == 4'd0)
                        begin
                            q_sav_sec  = 4'd0;
                            q_sav_ten  = 4'd0;
                            q_counting = 1'b0;
                        end
                    end
                    else if (q_alt_cnt >= q_cfg_alt)
                    begin
                        if (q_sec == DASH_CODE)
                        begin
                            q_sec = q_sav_sec;
                            q_ten = q_sav_ten;
                        end
                        else
                        begin
                            q_sec = DASH_CODE;
                            q_ten = (q_answer != ANS_NONE) ? DASH_CODE + 4'(q_answer)
                                                           : DASH_CODE;
                        end
                        q_alt_cnt = 4'd0;
                    end
                    else
                    begin
                        q_alt_cnt = q_alt_cnt + 4'd1;
                    end
                end
            end
        endcase
        r.left_segments  = LEFT_SEGS[q_sec * 8 +: 8];
        r.right_segments = RIGHT_SEGS[q_ten * 8 +: 8];
        r.left_code      = q_sec;
        r.right_code     = q_ten;
        r.is_counting    = q_counting;
        r.answer_out     = q_answer;
    endtask

    // Sender: present the head of buzz_q, hold it until taken.
    always @(posedge clk or negedge rst_n)
    begin : drive_events
        result_t r;
        bit      go;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= 8'h00;
            s_tuser  <= 2'b00;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                step_quiz_timer(buzz_q[0].kind, buzz_q[0].lines, r);
                display_q.push_back(r);
                void'(buzz_q.pop_front());
            end
            if (!(s_tvalid && !s_tready))
            begin
                go = (buzz_q.size() != 0) && !hold_sender && ($urandom_range(99) >= idle_pct);
                s_tvalid <= go;
                if (go)
                begin
                    s_tdata <= {4'b0000, buzz_q[0].lines};
                    s_tuser <= buzz_q[0].kind;
                end
            end
        end
    end

    // Receiver: check every result beat against the oldest prediction.
    always @(posedge clk or negedge rst_n)
    begin : check_display
        result_t got;
        result_t want;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got = m_tdata[27:0];
                if (display_q.size() == 0)
                begin
                    flag_mismatch("result beat with nothing pending", int'(got), 0);
                end
                else
                begin
                    want = display_q.pop_front();
                    if (got.left_segments != want.left_segments)
                        flag_mismatch("left_segments", int'(got.left_segments),
                                      int'(want.left_segments));
                    if (got.right_segments != want.right_segments)
                        flag_mismatch("right_segments", int'(got.right_segments),
                                      int'(want.right_segments));
                    if (got.left_code != want.left_code)
                        flag_mismatch("left_code", int'(got.left_code), int'(want.left_code));
                    if (got.right_code != want.right_code)
                        flag_mismatch("right_code", int'(got.right_code),
                                      int'(want.right_code));
                    if (got.is_counting != want.is_counting)
                        flag_mismatch("is_counting", int'(got.is_counting),
                                      int'(want.is_counting));
                    if (got.answer_out != want.answer_out)
                        flag_mismatch("answer_out", int'(got.answer_out),
                                      int'(want.answer_out));
                end
            end
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    task automatic write_reg(input cfg_index_t idx, input logic [3:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_START_SECONDS)
            q_cfg_start = val;
        else
            q_cfg_alt = val;
    endtask

    task automatic push_buzz(input kind_t k, input logic [3:0] lines);
        buzz_t b;
        b.kind  = k;
        b.lines = lines;
        buzz_q.push_back(b);
    endtask

    task automatic push_noise();
        push_buzz(kind_t'($urandom_range(3)), 4'($urandom_range(15)));
    endtask

    task automatic push_ticks(input int n);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(9) == 0)
                push_noise();
            else if ($urandom_range(15) == 0)
                push_buzz(KIND_DEBNC, 4'($urandom_range(15)));
            push_buzz(KIND_COUNT, 4'($urandom_range(15)));
        end
    endtask

    // One quiz round: re-arm, start, count down, answer (or run out), alternate.
    task automatic push_round();
        int n;
        push_buzz(KIND_DEBNC, 4'($urandom_range(15)));
        push_buzz(KIND_START, 4'($urandom_range(15)));
        push_buzz(KIND_DEBNC, 4'($urandom_range(15)));
        push_buzz(KIND_START, 4'($urandom_range(15)));
        n = ($urandom_range(9) == 0) ? $urandom_range(60, 200) : $urandom_range(1, 25);
        push_ticks(n);
        if ($urandom_range(5) != 0)
            push_buzz(KIND_ANSWER, 4'($urandom_range(15)));
        push_ticks($urandom_range(0, 35));
    endtask

    task automatic drain();
        int guard;
        do @(posedge clk); while (buzz_q.size() != 0 || s_tvalid);
        guard = 0;
        while (display_q.size() != 0 && guard < 5000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic run_random_phase(input logic [3:0] start_s, input logic [3:0] alt,
                                    input int idle, input int stall, input bit pause);
        write_reg(CFG_START_SECONDS, start_s);
        write_reg(CFG_ALTERNATE_TICKS, alt);
        idle_pct  = idle;
        stall_pct = stall;
        while (buzz_q.size() < 100)
            push_round();
        if (pause)
        begin
            do @(posedge clk); while (buzz_q.size() > 75);
            hold_sender = 1'b1;
            do @(posedge clk); while (s_tvalid || display_q.size() != 0);
            hold_sender = 1'b0;
        end
        drain();
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: start value above nine, alternation on every tick
        write_reg(CFG_START_SECONDS, 4'd12);
        write_reg(CFG_ALTERNATE_TICKS, 4'd0);
        push_buzz(KIND_ANSWER, 4'b0000);   // answer not yet enabled
        push_buzz(KIND_COUNT,  4'b1111);   // timer stopped
        push_buzz(KIND_DEBNC,  4'b0000);   // debounce stopped
        push_buzz(KIND_START,  4'b1010);
        push_buzz(KIND_START,  4'b0101);   // start disabled
        push_buzz(KIND_COUNT,  4'b0000);
        push_buzz(KIND_COUNT,  4'b1111);
        push_buzz(KIND_DEBNC,  4'b1111);
        push_buzz(KIND_ANSWER, 4'b0000);   // all lines low, D wins
        push_buzz(KIND_ANSWER, 4'b1110);   // frozen, ignored
        push_buzz(KIND_COUNT,  4'b0000);
        push_buzz(KIND_COUNT,  4'b0000);
        push_buzz(KIND_COUNT,  4'b0000);
        push_buzz(KIND_DEBNC,  4'b0000);
        push_buzz(KIND_START,  4'b0000);   // re-arm, loads clamped 9.0
        push_buzz(KIND_START,  4'b1111);
        push_buzz(KIND_COUNT,  4'b1111);
        push_buzz(KIND_COUNT,  4'b1111);
        push_buzz(KIND_DEBNC,  4'b1111);
        push_buzz(KIND_ANSWER, 4'b1111);   // no line low, answer stays none
        push_buzz(KIND_COUNT,  4'b1111);
        push_buzz(KIND_COUNT,  4'b1111);
        push_buzz(KIND_DEBNC,  4'b1111);
        push_buzz(KIND_START,  4'b1111);
        push_buzz(KIND_START,  4'b1111);
        drain();

        run_random_phase(4'd5, 4'd14, 0, 0, 1'b0);
        run_random_phase(4'd0, 4'd15, 50, 0, 1'b0);
        run_random_phase(4'd9, 4'd1, 0, 50, 1'b0);
        run_random_phase(4'd3, 4'd7, 31, 31, 1'b1);

        if (display_q.size() != 0)
            flag_mismatch("results never delivered", display_q.size(), 0);
        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

### files.f
rtl/act_pkg.sv
rtl/answer_countdown_timer.sv
tb/answer_countdown_timer_test.sv
